### rtl/core/websocket_frame_delimiter_top_macros.svh
// Assertion macros shared by the frame delimiter RTL.
`ifndef WEBSOCKET_FRAME_DELIMITER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DELIMITER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define WSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wsfd_pkg.sv
// Package: types and constants of the WebSocket frame delimiter.
package wsfd_pkg;

  // Payload length register width default
  localparam int unsigned LENGTH_BITS_DEF = 32;

  // Depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // Header byte 1 fields
  localparam int unsigned MASK_BIT_POS = 7;
  localparam logic [6:0]  CODE_16      = 7'd126;
  localparam logic [6:0]  CODE_64      = 7'd127;

  // Header sizes in bytes
  localparam logic [3:0] HDR_BASE       = 4'd2;
  localparam logic [3:0] MASK_KEY_BYTES = 4'd4;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;

  // Header positions of interest
  localparam logic [3:0] POS_FIRST     = 4'd0;
  localparam logic [3:0] POS_LEN       = 4'd1;
  localparam logic [3:0] POS_LAST_EXT16 = 4'd3;
  localparam logic [3:0] POS_LAST_EXT64 = 4'd9;

  // Parser state
  typedef enum logic {
    ST_HEADER  = 1'b0,
    ST_PAYLOAD = 1'b1
  } st_e;

  // One classified stream byte
  typedef struct packed {
    logic [7:0] data;
    logic       masked;
    logic [6:0] code;
    logic       is16;
    logic       is64;
  } item_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic full;
    logic nonempty;
  } fifo_stat_t;

endpackage

### rtl/core/websocket_frame_delimiter_top.sv
// WebSocket receive frame delimiter: one stream byte in, the same byte out with
// in_header, frame_start and frame_end flags. It sustains one byte per cycle while
// the output is not stalled. A byte waits in the two-entry queue and then moves
// into the result register. The header and payload-count update in the back
// end, done once per byte, sets that rate. in_stall_o rises only when the
// queue is full. With bytes arriving every cycle, that happens once the output
// has been stalled. Payload lengths longer than LENGTH_BITS bits keep only
// their low bits.
module websocket_frame_delimiter_top #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       in_header_o,
  output logic       frame_start_o,
  output logic       frame_end_o
);
  import wsfd_pkg::*;
  `include "websocket_frame_delimiter_top_macros.svh"

  item_t      front_item, queue_item;
  fifo_stat_t fifo_stat;
  logic       push, pop;

  // Front: accept and decode
  wsfd_front u_front (
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .fifo_stat_i (fifo_stat),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  // Queue between front and back
  wsfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (fifo_stat)
  );

  // Back: frame tracking and result register
  wsfd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (queue_item),
    .fifo_stat_i   (fifo_stat),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .in_header_o   (in_header_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o)
  );

  // A frame start is always a header byte
  `WSFD_ASSERT_IMP(a_start_is_hdr, out_valid_o && frame_start_o, in_header_o, "start not header")
  // The header is at least two bytes, so a frame never starts and ends on one byte
  `WSFD_ASSERT_IMP(a_no_one_byte_frame, out_valid_o, !(frame_start_o && frame_end_o), "1-byte frame")
  // Input stalls only while the queue is full
  `WSFD_ASSERT_IMP(a_stall_full, in_stall_o, fifo_stat.full && fifo_stat.nonempty, "bad stall")
  // A pop with a free result register always yields a valid result next cycle
  `WSFD_ASSERT_NXT(a_pop_valid, pop, out_valid_o, "pop lost")

endmodule

### rtl/core/wsfd_front.sv
// Front end: accepts stream bytes and decodes the header byte 1 fields.
module wsfd_front (
  input  logic            in_valid_i,
  input  logic [7:0]      data_byte_i,
  input  wsfd_pkg::fifo_stat_t fifo_stat_i,
  output logic            in_stall_o,
  output logic            push_o,
  output wsfd_pkg::item_t item_o
);
  import wsfd_pkg::*;

  // Stall only when the queue has no room
  assign in_stall_o = fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  // Decode mask bit and length code as if this were header byte 1
  always_comb begin
    item_o.data   = data_byte_i;
    item_o.masked = data_byte_i[MASK_BIT_POS];
    item_o.code   = data_byte_i[6:0];
    item_o.is16   = (data_byte_i[6:0] == CODE_16);
    item_o.is64   = (data_byte_i[6:0] == CODE_64);
  end

endmodule

### rtl/core/wsfd_fifo.sv
// Small register queue between the front and back ends.
module wsfd_fifo #(
  parameter int unsigned DEPTH = wsfd_pkg::FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wsfd_pkg::item_t      item_i,
  input  logic                 pop_i,
  output wsfd_pkg::item_t      item_o,
  output wsfd_pkg::fifo_stat_t stat_o
);
  import wsfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full     = (cnt_q == CNT_FULL);
  assign stat_o.nonempty = (cnt_q != '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.nonempty;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/core/wsfd_back.sv
// Back end: header/payload tracking and the registered result stage.
module wsfd_back #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wsfd_pkg::item_t      item_i,
  input  wsfd_pkg::fifo_stat_t fifo_stat_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 in_header_o,
  output logic                 frame_start_o,
  output logic                 frame_end_o
);
  import wsfd_pkg::*;

  st_e                    state_q, state_d;
  logic [3:0]             hdr_pos_q, hdr_pos_d;
  logic [3:0]             hdr_len_q, hdr_len_d;
  logic [6:0]             code_q, code_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;

  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  logic                   in_header_q, frame_start_q, frame_end_q;

  logic [3:0]             pos_inc;
  logic [3:0]             hl_new;
  logic [LENGTH_BITS-1:0] rem_hdr, rem_dec;
  logic                   hdr_done, rem_zero;
  logic                   hdr_flag, start_flag, end_flag;

  // Take an item when the result register is free or drains this cycle
  assign pop_o = fifo_stat_i.nonempty && (!out_valid_q || !out_stall_i);

  // Shared datapath: header size, length field and payload countdown
  always_comb begin
    pos_inc = hdr_pos_q + 4'd1;
    hl_new  = hdr_len_q;
    code_d  = code_q;
    rem_hdr = rem_q;
    if (hdr_pos_q == POS_FIRST) begin
      hl_new = HDR_BASE;
    end else if (hdr_pos_q == POS_LEN) begin
      code_d  = item_i.code;
      hl_new  = HDR_BASE + (item_i.masked ? MASK_KEY_BYTES : 4'd0)
              + (item_i.is16 ? EXT16_BYTES : (item_i.is64 ? EXT64_BYTES : 4'd0));
      rem_hdr = (item_i.is16 || item_i.is64) ? '0 : LENGTH_BITS'(item_i.code);
    end else if ((code_q == CODE_16 && hdr_pos_q <= POS_LAST_EXT16) ||
                 (code_q == CODE_64 && hdr_pos_q <= POS_LAST_EXT64)) begin
      // Big-endian length byte, upper bits fall off the top
      rem_hdr = {rem_q[LENGTH_BITS-9:0], item_i.data};
    end
    hdr_done = (pos_inc >= hl_new);
    rem_dec  = (rem_q != '0) ? rem_q - LENGTH_BITS'(1) : rem_q;
    rem_zero = (state_q == ST_HEADER) ? (rem_hdr == '0) : (rem_dec == '0);
  end

  // Next state
  always_comb begin
    state_d   = state_q;
    hdr_pos_d = hdr_pos_q;
    hdr_len_d = hdr_len_q;
    rem_d     = rem_q;
    case (state_q)
      ST_HEADER: begin
        hdr_len_d = hl_new;
        rem_d     = rem_hdr;
        if (hdr_done) begin
          hdr_pos_d = POS_FIRST;
          if (rem_zero) begin
            hdr_len_d = HDR_BASE;
          end else begin
            state_d = ST_PAYLOAD;
          end
        end else begin
          hdr_pos_d = pos_inc;
        end
      end
      ST_PAYLOAD: begin
        rem_d = rem_dec;
        if (rem_zero) begin
          state_d   = ST_HEADER;
          hdr_pos_d = POS_FIRST;
          hdr_len_d = HDR_BASE;
        end
      end
      default: begin
        state_d = ST_HEADER;
      end
    endcase
  end

  // Per-byte flags
  always_comb begin
    hdr_flag   = 1'b0;
    start_flag = 1'b0;
    end_flag   = 1'b0;
    case (state_q)
      ST_HEADER: begin
        hdr_flag   = 1'b1;
        start_flag = (hdr_pos_q == POS_FIRST);
        end_flag   = hdr_done && rem_zero;
      end
      ST_PAYLOAD: begin
        end_flag = rem_zero;
      end
      default: begin
        end_flag = 1'b0;
      end
    endcase
  end

  // Parser state, advanced once per transfer out of the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HEADER;
      hdr_pos_q <= POS_FIRST;
      hdr_len_q <= HDR_BASE;
      code_q    <= '0;
      rem_q     <= '0;
    end else if (pop_o) begin
      state_q   <= state_d;
      hdr_pos_q <= hdr_pos_d;
      hdr_len_q <= hdr_len_d;
      code_q    <= code_d;
      rem_q     <= rem_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q    <= item_i.data;
      in_header_q   <= hdr_flag;
      frame_start_q <= start_flag;
      frame_end_q   <= end_flag;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign in_header_o   = in_header_q;
  assign frame_start_o = frame_start_q;
  assign frame_end_o   = frame_end_q;

endmodule

### verif/wsfd_frame_checker.sv
// Frame delimiter checker: predicts the tag flags of every byte and compares results.
module wsfd_frame_checker #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       in_header_i,
  input  logic       frame_start_i,
  input  logic       frame_end_i,
  output int         error_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsfd_pkg::*;

  // One tagged stream byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       in_header;
    logic       frame_start;
    logic       frame_end;
  } tagged_byte_t;

  // Parser copy: header position and size, length code, payload count
  st_e                    parse_st;
  logic [3:0]             hdr_pos;
  logic [3:0]             hdr_len;
  logic [6:0]             len_code;
  logic [LENGTH_BITS-1:0] body_left;

  tagged_byte_t tagged_q[$];
  int           fail_cnt = 0;

  assign error_count_o = fail_cnt;

  // Advance the parser by one byte and return the flags it earns
  function automatic tagged_byte_t frame_step(input logic [7:0] b);
    tagged_byte_t r;
    logic [3:0]   hl;
    logic [3:0]   nxt;
    r = '0;
    r.data = b;
    if (parse_st == ST_HEADER) begin
      r.in_header = 1'b1;
      if (hdr_pos == POS_FIRST) begin
        r.frame_start = 1'b1;
        hdr_len = HDR_BASE;
      end else if (hdr_pos == POS_LEN) begin
        len_code = b[6:0];
        hl = HDR_BASE;
        if (b[MASK_BIT_POS]) hl = hl + MASK_KEY_BYTES;
        if (len_code == CODE_16) hl = hl + EXT16_BYTES;
        else if (len_code == CODE_64) hl = hl + EXT64_BYTES;
        hdr_len = hl;
        body_left = (len_code < CODE_16) ? LENGTH_BITS'(len_code) : '0;
      end else if ((len_code == CODE_16 && hdr_pos <= POS_LAST_EXT16) ||
                   (len_code == CODE_64 && hdr_pos <= POS_LAST_EXT64)) begin
        // big-endian length bytes; high bytes fall off the top
        body_left = {body_left[LENGTH_BITS-9:0], b};
      end
      nxt = hdr_pos + 4'd1;
      if (nxt >= hdr_len) begin
        hdr_pos = POS_FIRST;
        if (body_left == '0) begin
          // zero-length payload ends the frame on its last header byte
          r.frame_end = 1'b1;
          hdr_len = HDR_BASE;
        end else begin
          parse_st = ST_PAYLOAD;
        end
      end else begin
        hdr_pos = nxt;
      end
    end else begin
      if (body_left != '0) body_left = body_left - LENGTH_BITS'(1);
      if (body_left == '0) begin
        r.frame_end = 1'b1;
        parse_st = ST_HEADER;
        hdr_pos = POS_FIRST;
        hdr_len = HDR_BASE;
      end
    end
    return r;
  endfunction

  // Watch both channels: compare output transfers, predict input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    tagged_byte_t seen;
    tagged_byte_t want;
    if (!rst_ni) begin
      parse_st = ST_HEADER;
      hdr_pos = POS_FIRST;
      hdr_len = HDR_BASE;
      len_code = '0;
      body_left = '0;
      tagged_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen.data = out_byte_i;
        seen.in_header = in_header_i;
        seen.frame_start = frame_start_i;
        seen.frame_end = frame_end_i;
        if (tagged_q.size() == 0) begin
          $display("%0t: unexpected output byte %02h", $time, seen.data);
          fail_cnt++;
        end else begin
          want = tagged_q.pop_front();
          if (seen.data !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.data, seen.data);
            fail_cnt++;
          end
          if (seen.in_header !== want.in_header) begin
            $display("%0t: in_header expected %b, got %b", $time, want.in_header,
                     seen.in_header);
            fail_cnt++;
          end
          if (seen.frame_start !== want.frame_start) begin
            $display("%0t: frame_start expected %b, got %b", $time, want.frame_start,
                     seen.frame_start);
            fail_cnt++;
          end
          if (seen.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b, got %b", $time, want.frame_end,
                     seen.frame_end);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) tagged_q = {tagged_q, frame_step(data_byte_i)};
      pending_o <= tagged_q.size();
    end
  end

endmodule

### verif/tb_websocket_frame_delimiter_top.sv
// Testbench top: drives framed byte streams with random gaps and stalls, reports the verdict.
module tb_websocket_frame_delimiter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsfd_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       in_header_o;
  logic       frame_start_o;
  logic       frame_end_o;

  int   err_cnt;
  int   pending_cnt;
  int   sent_cnt = 0;
  int   stall_left = 0;
  logic in_quiet = 1'b0;
  logic out_quiet = 1'b0;

  websocket_frame_delimiter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .in_header_o  (in_header_o),
    .frame_start_o(frame_start_o),
    .frame_end_o  (frame_end_o)
  );

  wsfd_frame_checker frame_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .in_header_i  (in_header_o),
    .frame_start_i(frame_start_o),
    .frame_end_i  (frame_end_o),
    .error_count_o(err_cnt),
    .pending_o    (pending_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Output stall pattern, with quiet stretches that never stall
  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (!out_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if ($urandom_range(0, 299) == 0) out_quiet = !out_quiet;
    out_stall_i <= (stall_left != 0);
  end

  // One byte transfer, then an optional idle gap
  task automatic push_byte(input logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    gap = in_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One well-formed frame with random header bits, mask key and payload
  task automatic send_frame();
    logic [7:0]  fb[$];
    logic [31:0] plen;
    logic [6:0]  code;
    logic        masked;
    int          kind;
    kind = $urandom_range(0, 99);
    masked = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) plen = $urandom_range(126, 600);
    else plen = $urandom_range(0, 40);
    if (kind < 70) begin
      code = ($urandom_range(0, 19) == 0) ? 7'd125 : 7'($urandom_range(0, 30));
      plen = 32'(code);
    end else if (kind < 85) begin
      code = CODE_16;
    end else begin
      code = CODE_64;
    end
    fb = {fb, 8'($urandom_range(0, 255))};
    fb = {fb, {masked, code}};
    if (code == CODE_16) begin
      fb = {fb, plen[15:8]};
      fb = {fb, plen[7:0]};
    end else if (code == CODE_64) begin
      // upper length bytes carry junk that the block must drop
      repeat (4) fb = {fb, 8'($urandom_range(0, 255))};
      fb = {fb, plen[31:24]};
      fb = {fb, plen[23:16]};
      fb = {fb, plen[15:8]};
      fb = {fb, plen[7:0]};
    end
    if (masked) repeat (4) fb = {fb, 8'($urandom_range(0, 255))};
    repeat (plen) fb = {fb, 8'($urandom_range(0, 255))};
    foreach (fb[i]) push_byte(fb[i]);
    if ($urandom_range(0, 9) == 0) in_quiet = !in_quiet;
  endtask

  // Stimulus and verdict
  initial begin
    logic [7:0] directed_q[$];
    // zero payload unmasked, zero payload masked, 16-bit zero length,
    // oversized 64-bit length whose low word is zero, one-byte payload
    directed_q = '{8'h82, 8'h00,
                   8'hFF, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A,
                   8'h01, 8'h7E, 8'h00, 8'h00,
                   8'h02, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h82, 8'h01, 8'hFF};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_q[i]) push_byte(directed_q[i]);
    while (sent_cnt < 2000) send_frame();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_websocket_frame_delimiter_top: done, clean");
    end else begin
      $display("tb_websocket_frame_delimiter_top: done, errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("tb_websocket_frame_delimiter_top: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/wsfd_pkg.sv
rtl/core/wsfd_front.sv
rtl/core/wsfd_fifo.sv
rtl/core/wsfd_back.sv
rtl/core/websocket_frame_delimiter_top.sv
verif/wsfd_frame_checker.sv
verif/tb_websocket_frame_delimiter_top.sv
